// ----- hdl/lsi_pkg.sv -----
// shared constants and types for the line and segment intersection unit
package lsi_pkg;

    localparam int STRETCH = 10;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_pipe_ctl;

endpackage

// ----- hdl/lsi_front.sv -----
// geometry pipeline: line stretch, orientation tests, determinant and cramer numerators
module lsi_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [COORD_BITS-1:0]     i_ax,
    input  logic [COORD_BITS-1:0]     i_ay,
    input  logic [COORD_BITS-1:0]     i_bx,
    input  logic [COORD_BITS-1:0]     i_by,
    input  logic [COORD_BITS-1:0]     i_sx,
    input  logic [COORD_BITS-1:0]     i_sy,
    input  logic [COORD_BITS-1:0]     i_ex,
    input  logic [COORD_BITS-1:0]     i_ey,
    output lsi_pkg::t_pipe_ctl        o_ctl,
    output logic [3*COORD_BITS+2:0]   o_num_x,
    output logic [3*COORD_BITS+2:0]   o_num_y,
    output logic [2*COORD_BITS+2:0]   o_den
);

    localparam int N   = COORD_BITS;
    localparam int DW1 = N + 1;
    localparam int LW  = N + 9;
    localparam int DLW = LW + 1;
    localparam int PW  = 2 * DLW;
    localparam int OW  = PW + 1;
    localparam int CW  = 2 * N + 1;
    localparam int DTW = 2 * N + 3;
    localparam int PPW = CW + DW1;
    localparam int NUW = 3 * N + 3;
    localparam logic signed [LW-1:0] K = LW'(lsi_pkg::STRETCH);

    // stage 1: stretched first point
    logic signed [LW-1:0] ae_x, ae_y, be_x, be_y;
    logic signed [LW-1:0] n1_lax, n1_lay;
    logic                 r1_v;
    logic [N-1:0]         r1_ax, r1_ay, r1_bx, r1_by, r1_sx, r1_sy, r1_ex, r1_ey;
    logic signed [LW-1:0] r1_lax, r1_lay;

    assign ae_x   = $signed({{(LW-N){1'b0}}, i_ax});
    assign ae_y   = $signed({{(LW-N){1'b0}}, i_ay});
    assign be_x   = $signed({{(LW-N){1'b0}}, i_bx});
    assign be_y   = $signed({{(LW-N){1'b0}}, i_by});
    assign n1_lax = ae_x + K * (ae_x - be_x);
    assign n1_lay = ae_y + K * (ae_y - be_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_ax  <= i_ax;
            r1_ay  <= i_ay;
            r1_bx  <= i_bx;
            r1_by  <= i_by;
            r1_sx  <= i_sx;
            r1_sy  <= i_sy;
            r1_ex  <= i_ex;
            r1_ey  <= i_ey;
            r1_lax <= n1_lax;
            r1_lay <= n1_lay;
        end
    end

    // stage 2: stretched second point
    logic signed [LW-1:0] b1_x, b1_y, n2_lbx, n2_lby;
    logic                 r2_v;
    logic [N-1:0]         r2_ax, r2_ay, r2_bx, r2_by, r2_sx, r2_sy, r2_ex, r2_ey;
    logic signed [LW-1:0] r2_lax, r2_lay, r2_lbx, r2_lby;

    assign b1_x   = $signed({{(LW-N){1'b0}}, r1_bx});
    assign b1_y   = $signed({{(LW-N){1'b0}}, r1_by});
    assign n2_lbx = b1_x + K * (b1_x - r1_lax);
    assign n2_lby = b1_y + K * (b1_y - r1_lay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_bx  <= r1_bx;
            r2_by  <= r1_by;
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_ex  <= r1_ex;
            r2_ey  <= r1_ey;
            r2_lax <= r1_lax;
            r2_lay <= r1_lay;
            r2_lbx <= n2_lbx;
            r2_lby <= n2_lby;
        end
    end

    // stage 3: orientation, determinant and line-constant products
    logic signed [DLW-1:0] lax, lay, lbx, lby, sxl, syl, exl, eyl;
    logic signed [DLW-1:0] d_ly, d_lx, d_sy, d_sx;
    logic signed [DW1-1:0] n3_dx, n3_dy, n3_sdx, n3_sdy;
    logic                  r3_v;
    logic signed [PW-1:0]  r3_u1, r3_w1, r3_u2, r3_w2, r3_u3, r3_w3, r3_u4, r3_w4;
    logic signed [2*DW1-1:0] r3_dt1, r3_dt2;
    logic [2*N-1:0]        r3_c1a, r3_c1b, r3_c2a, r3_c2b;
    logic signed [DW1-1:0] r3_dx, r3_dy, r3_sdx, r3_sdy;

    assign lax  = DLW'(r2_lax);
    assign lay  = DLW'(r2_lay);
    assign lbx  = DLW'(r2_lbx);
    assign lby  = DLW'(r2_lby);
    assign sxl  = $signed({{(DLW-N){1'b0}}, r2_sx});
    assign syl  = $signed({{(DLW-N){1'b0}}, r2_sy});
    assign exl  = $signed({{(DLW-N){1'b0}}, r2_ex});
    assign eyl  = $signed({{(DLW-N){1'b0}}, r2_ey});
    assign d_ly = lby - lay;
    assign d_lx = lbx - lax;
    assign d_sy = eyl - syl;
    assign d_sx = exl - sxl;
    assign n3_dx  = $signed({1'b0, r2_ax}) - $signed({1'b0, r2_bx});
    assign n3_dy  = $signed({1'b0, r2_ay}) - $signed({1'b0, r2_by});
    assign n3_sdx = $signed({1'b0, r2_sx}) - $signed({1'b0, r2_ex});
    assign n3_sdy = $signed({1'b0, r2_sy}) - $signed({1'b0, r2_ey});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_u1  <= d_ly * (sxl - lbx);
            r3_w1  <= d_lx * (syl - lby);
            r3_u2  <= d_ly * (exl - lbx);
            r3_w2  <= d_lx * (eyl - lby);
            r3_u3  <= d_sy * (lax - exl);
            r3_w3  <= d_sx * (lay - eyl);
            r3_u4  <= d_sy * (lbx - exl);
            r3_w4  <= d_sx * (lby - eyl);
            r3_dt1 <= n3_dx * n3_sdy;
            r3_dt2 <= n3_dy * n3_sdx;
            r3_c1a <= r2_ax * r2_by;
            r3_c1b <= r2_ay * r2_bx;
            r3_c2a <= r2_sx * r2_ey;
            r3_c2b <= r2_sy * r2_ex;
            r3_dx  <= n3_dx;
            r3_dy  <= n3_dy;
            r3_sdx <= n3_sdx;
            r3_sdy <= n3_sdy;
        end
    end

    // stage 4: orientation signs, determinant, line constants
    logic signed [OW-1:0]  o1, o2, o3, o4;
    logic [1:0]            g1, g2, g3, g4;
    logic signed [DTW-1:0] n4_det;
    logic                  r4_v, r4_hit;
    logic signed [DTW-1:0] r4_det;
    logic signed [CW-1:0]  r4_c1, r4_c2;
    logic signed [DW1-1:0] r4_dx, r4_dy, r4_sdx, r4_sdy;

    assign o1 = OW'(r3_u1) - OW'(r3_w1);
    assign o2 = OW'(r3_u2) - OW'(r3_w2);
    assign o3 = OW'(r3_u3) - OW'(r3_w3);
    assign o4 = OW'(r3_u4) - OW'(r3_w4);
    assign g1 = {o1[OW-1], o1 != '0};
    assign g2 = {o2[OW-1], o2 != '0};
    assign g3 = {o3[OW-1], o3 != '0};
    assign g4 = {o4[OW-1], o4 != '0};
    assign n4_det = DTW'(r3_dt1) - DTW'(r3_dt2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
        if (i_en) begin
            r4_hit <= (g1 != g2) && (g3 != g4) && (n4_det != '0);
            r4_det <= n4_det;
            r4_c1  <= $signed({1'b0, r3_c1a}) - $signed({1'b0, r3_c1b});
            r4_c2  <= $signed({1'b0, r3_c2a}) - $signed({1'b0, r3_c2b});
            r4_dx  <= r3_dx;
            r4_dy  <= r3_dy;
            r4_sdx <= r3_sdx;
            r4_sdy <= r3_sdy;
        end
    end

    // stage 5: numerator products
    logic                  r5_v, r5_hit;
    logic signed [DTW-1:0] r5_det;
    logic signed [PPW-1:0] r5_px1, r5_px2, r5_py1, r5_py2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= r4_v;
        end
        if (i_en) begin
            r5_hit <= r4_hit;
            r5_det <= r4_det;
            r5_px1 <= r4_c1 * r4_sdx;
            r5_px2 <= r4_dx * r4_c2;
            r5_py1 <= r4_c1 * r4_sdy;
            r5_py2 <= r4_dy * r4_c2;
        end
    end

    // stage 6: numerators and magnitudes
    logic signed [NUW-1:0] nx, ny;
    logic                  r6_v, r6_hit;
    logic [NUW-1:0]        r6_mx, r6_my;
    logic [DTW-1:0]        r6_md;

    assign nx = NUW'(r5_px1) - NUW'(r5_px2);
    assign ny = NUW'(r5_py1) - NUW'(r5_py2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (i_en) begin
            r6_v <= r5_v;
        end
        if (i_en) begin
            r6_hit <= r5_hit;
            r6_mx  <= nx[NUW-1] ? NUW'(-nx) : NUW'(nx);
            r6_my  <= ny[NUW-1] ? NUW'(-ny) : NUW'(ny);
            r6_md  <= r5_det[DTW-1] ? DTW'(-r5_det) : DTW'(r5_det);
        end
    end

    assign o_ctl.valid = r6_v;
    assign o_ctl.hit   = r6_hit;
    assign o_num_x     = r6_mx;
    assign o_num_y     = r6_my;
    assign o_den       = r6_md;

endmodule

// ----- hdl/lsi_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module lsi_div #(
    parameter int NW = 39,
    parameter int DW = 27,
    parameter int QW = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  lsi_pkg::t_pipe_ctl i_ctl,
    input  logic [NW-1:0]      i_num,
    input  logic [DW-1:0]      i_den,
    output lsi_pkg::t_pipe_ctl o_ctl,
    output logic [QW-1:0]      o_quo
);

    localparam int SW = (NW > DW + QW) ? NW : DW + QW;

    lsi_pkg::t_pipe_ctl r_ctl [QW];
    logic [NW-1:0]      r_rem [QW];
    logic [DW-1:0]      r_den [QW];
    logic [QW-1:0]      r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;
        lsi_pkg::t_pipe_ctl ctl_in;
        logic [NW-1:0]      rem_in;
        logic [DW-1:0]      den_in;
        logic [QW-1:0]      quo_in;
        logic [SW-1:0]      trial;
        logic [SW-1:0]      rem_ext;
        logic               ge;
        logic [NW-1:0]      n_rem;
        logic [QW-1:0]      n_quo;

        if (k == 0) begin : g_first
            assign ctl_in = i_ctl;
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign ctl_in = r_ctl[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial   = SW'(den_in) << SH;
        assign rem_ext = SW'(rem_in);
        assign ge      = rem_ext >= trial;
        assign n_rem   = ge ? NW'(rem_ext - trial) : rem_in;
        always_comb begin
            n_quo     = quo_in;
            n_quo[SH] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= ctl_in;
            end
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_ctl = r_ctl[QW-1];
    assign o_quo = r_quo[QW-1];

endmodule

// ----- hdl/line_segment_intersection_unit.sv -----
// top level of the line and segment intersection unit
//
//  channel | valid        | stall         | payload
//  --------+--------------+---------------+---------------------------------------
//  in      | i_in_valid   | o_in_stall    | i_line_a_*, i_line_b_*, i_seg_start_*,
//          |              |               | i_seg_end_*
//  out     | o_out_valid  | i_out_stall   | o_hit, o_cross_x, o_cross_y
//
// one request per cycle while the pipeline is not held; six geometry stages,
// one divider stage per quotient bit, one output register.
// the whole pipeline advances together and holds while the output register is full and
// stalled; o_in_stall follows that hold.
// synchronous active-low reset clears every valid bit.
module line_segment_intersection_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_line_a_x,
    input  logic [COORD_BITS-1:0] i_line_a_y,
    input  logic [COORD_BITS-1:0] i_line_b_x,
    input  logic [COORD_BITS-1:0] i_line_b_y,
    input  logic [COORD_BITS-1:0] i_seg_start_x,
    input  logic [COORD_BITS-1:0] i_seg_start_y,
    input  logic [COORD_BITS-1:0] i_seg_end_x,
    input  logic [COORD_BITS-1:0] i_seg_end_y,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic [COORD_BITS-1:0] o_cross_x,
    output logic [COORD_BITS-1:0] o_cross_y
);

    localparam int NUW = 3 * COORD_BITS + 3;
    localparam int DTW = 2 * COORD_BITS + 3;

    logic                  en;
    lsi_pkg::t_pipe_ctl    geo_ctl, qx_ctl, qy_ctl;
    logic [NUW-1:0]        num_x, num_y;
    logic [DTW-1:0]        den;
    logic [COORD_BITS-1:0] qx, qy;
    logic                  r_out_valid, r_hit;
    logic [COORD_BITS-1:0] r_cx, r_cy;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    lsi_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_ax    (i_line_a_x),
        .i_ay    (i_line_a_y),
        .i_bx    (i_line_b_x),
        .i_by    (i_line_b_y),
        .i_sx    (i_seg_start_x),
        .i_sy    (i_seg_start_y),
        .i_ex    (i_seg_end_x),
        .i_ey    (i_seg_end_y),
        .o_ctl   (geo_ctl),
        .o_num_x (num_x),
        .o_num_y (num_y),
        .o_den   (den)
    );

    lsi_div #(.NW(NUW), .DW(DTW), .QW(COORD_BITS)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (geo_ctl),
        .i_num   (num_x),
        .i_den   (den),
        .o_ctl   (qx_ctl),
        .o_quo   (qx)
    );

    lsi_div #(.NW(NUW), .DW(DTW), .QW(COORD_BITS)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (geo_ctl),
        .i_num   (num_y),
        .i_den   (den),
        .o_ctl   (qy_ctl),
        .o_quo   (qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= qx_ctl.valid && qy_ctl.valid;
        end
        if (en) begin
            r_hit <= qx_ctl.hit;
            r_cx  <= qx_ctl.hit ? qx : '0;
            r_cy  <= qx_ctl.hit ? qy : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_cross_x   = r_cx;
    assign o_cross_y   = r_cy;

endmodule

// ----- tb/sv/line_segment_intersection_unit_tb.sv -----
// testbench for the line and segment intersection unit: directed table then random checked requests
`timescale 1ns / 1ps

module line_segment_intersection_unit_tb;

    localparam int COORD_BITS = 12;
    localparam int LATENCY = COORD_BITS + 7;
    localparam int N_DIRECTED = 12;
    localparam int N_RANDOM = 900;
    localparam int N_TOTAL = N_DIRECTED + N_RANDOM;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord ax, ay, bx, by, sx, sy, ex, ey;
    } t_query;

    typedef struct {
        logic   hit;
        t_coord cx;
        t_coord cy;
    } t_crossing;

    typedef struct {
        t_query    q;
        logic      known;
        t_crossing res;
    } t_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_coord i_line_a_x = '0, i_line_a_y = '0, i_line_b_x = '0, i_line_b_y = '0;
    t_coord i_seg_start_x = '0, i_seg_start_y = '0, i_seg_end_x = '0, i_seg_end_y = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    logic   o_hit;
    t_coord o_cross_x, o_cross_y;

    line_segment_intersection_unit #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_line_a_x(i_line_a_x), .i_line_a_y(i_line_a_y),
        .i_line_b_x(i_line_b_x), .i_line_b_y(i_line_b_y),
        .i_seg_start_x(i_seg_start_x), .i_seg_start_y(i_seg_start_y),
        .i_seg_end_x(i_seg_end_x), .i_seg_end_y(i_seg_end_y),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_hit(o_hit), .o_cross_x(o_cross_x), .o_cross_y(o_cross_y)
    );

    always #2 i_clk = ~i_clk;

    t_crossing expected_crossings[N_TOTAL];
    int  wr_ptr = 0;
    int  rd_ptr = 0;
    int  n_mismatch = 0;
    int  n_hits = 0;
    int  n_checked = 0;
    int  cycle_count = 0;
    bit  quiet_stretch = 1'b0;

    function automatic int orient(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
        longint v;
        v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        if (v == 0) return 0;
        return (v > 0) ? 1 : 2;
    endfunction

    function automatic t_crossing predict_crossing(t_query q);
        longint ax, ay, bx, by, sx, sy, ex, ey;
        longint lax, lay, lbx, lby, det, c1, c2, nx, ny;
        t_crossing r;
        ax = q.ax; ay = q.ay; bx = q.bx; by = q.by;
        sx = q.sx; sy = q.sy; ex = q.ex; ey = q.ey;
        lax = ax + 10 * (ax - bx);
        lay = ay + 10 * (ay - by);
        lbx = bx + 10 * (bx - lax);
        lby = by + 10 * (by - lay);
        r = '{1'b0, '0, '0};
        if (orient(lax, lay, lbx, lby, sx, sy) != orient(lax, lay, lbx, lby, ex, ey) &&
            orient(sx, sy, ex, ey, lax, lay) != orient(sx, sy, ex, ey, lbx, lby)) begin
            det = (ax - bx) * (sy - ey) - (ay - by) * (sx - ex);
            if (det != 0) begin
                c1 = ax * by - ay * bx;
                c2 = sx * ey - sy * ex;
                nx = c1 * (sx - ex) - (ax - bx) * c2;
                ny = c1 * (sy - ey) - (ay - by) * c2;
                r.hit = 1'b1;
                r.cx = t_coord'(nx / det);
                r.cy = t_coord'(ny / det);
            end
        end
        return r;
    endfunction

    function automatic t_coord rnd_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CMAX;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_query random_query();
        t_query q;
        t_coord mx, my, tmp;
        q.ax = rnd_coord(); q.ay = rnd_coord();
        q.bx = rnd_coord(); q.by = rnd_coord();
        if ($urandom_range(0, 3) != 0) begin
            // segment straddling the midpoint of line ab so that hits are common
            mx = t_coord'((int'(q.ax) + int'(q.bx)) / 2);
            my = t_coord'((int'(q.ay) + int'(q.by)) / 2);
            q.sx = t_coord'($urandom_range(0, mx)); q.ex = t_coord'($urandom_range(mx, CMAX));
            q.sy = t_coord'($urandom_range(my, CMAX)); q.ey = t_coord'($urandom_range(0, my));
            if ($urandom_range(0, 1)) begin
                tmp = q.sx;
                q.sx = q.ex;
                q.ex = tmp;
            end
        end else begin
            q.sx = rnd_coord(); q.sy = rnd_coord();
            q.ex = rnd_coord(); q.ey = rnd_coord();
        end
        return q;
    endfunction

    task automatic send_request(t_query q);
        while (!quiet_stretch && $urandom_range(0, 99) < 35) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_line_a_x <= q.ax; i_line_a_y <= q.ay;
        i_line_b_x <= q.bx; i_line_b_y <= q.by;
        i_seg_start_x <= q.sx; i_seg_start_y <= q.sy;
        i_seg_end_x <= q.ex; i_seg_end_y <= q.ey;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    t_row directed[N_DIRECTED];

    initial begin
        t_query q;
        t_crossing exp_r;
        directed[0] = '{'{'0, '0, '0, '0, '0, '0, '0, '0}, 1'b1, '{1'b0, '0, '0}};
        directed[1] = '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1,
                        '{1'b0, '0, '0}};
        // parallel lines never hit
        directed[2] = '{'{0, 0, 100, 0, 0, 10, 100, 10}, 1'b1, '{1'b0, '0, '0}};
        // plain crossing at (50,50)
        directed[3] = '{'{0, 50, 100, 50, 50, 0, 50, 100}, 1'b1, '{1'b1, 50, 50}};
        // full-range diagonals
        directed[4] = '{'{0, 0, CMAX, CMAX, 0, CMAX, CMAX, 0}, 1'b0, '{1'b0, '0, '0}};
        // segment endpoint on the line
        directed[5] = '{'{0, 0, 10, 0, 5, 0, 5, 9}, 1'b0, '{1'b0, '0, '0}};
        // colinear segment
        directed[6] = '{'{0, 0, 10, 10, 20, 20, 30, 30}, 1'b0, '{1'b0, '0, '0}};
        // segment beyond the stretched line
        directed[7] = '{'{2000, 2000, 2001, 2000, 4095, 0, 4095, 4095}, 1'b0,
                        '{1'b0, '0, '0}};
        directed[8] = '{'{CMAX, 0, 0, CMAX, 0, 0, CMAX, CMAX}, 1'b0, '{1'b0, '0, '0}};
        // non-integer crossing, truncation
        directed[9] = '{'{0, 0, 3, 1, 1, 0, 1, 7}, 1'b0, '{1'b0, '0, '0}};
        directed[10] = '{'{4094, 1, 1, 4094, 2048, 0, 2047, 4095}, 1'b0, '{1'b0, '0, '0}};
        // degenerate line (a equals b)
        directed[11] = '{'{7, 7, 7, 7, 0, 0, 20, 20}, 1'b0, '{1'b0, '0, '0}};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            exp_r = directed[k].known ? directed[k].res : predict_crossing(directed[k].q);
            expected_crossings[wr_ptr] = exp_r;
            wr_ptr = wr_ptr + 1;
            send_request(directed[k].q);
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            quiet_stretch = (k >= 300 && k < 450);
            q = random_query();
            expected_crossings[wr_ptr] = predict_crossing(q);
            wr_ptr = wr_ptr + 1;
            send_request(q);
        end
        i_in_valid <= 1'b0;
        wait (rd_ptr == wr_ptr);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("covered %0d requests, %0d hits, directed extremes and random straddling segments",
                 n_checked, n_hits);
        if (n_mismatch == 0 && rd_ptr == wr_ptr) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= (!quiet_stretch && $urandom_range(0, 99) < 35);
    end

    always @(posedge i_clk) begin
        t_crossing e;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rd_ptr == wr_ptr) begin
                n_mismatch <= n_mismatch + 1;
                if (n_mismatch < 10) $display("unexpected result hit=%0b", o_hit);
            end else begin
                e = expected_crossings[rd_ptr];
                rd_ptr = rd_ptr + 1;
                n_checked <= n_checked + 1;
                if (e.hit) n_hits <= n_hits + 1;
                if (o_hit !== e.hit || o_cross_x !== e.cx || o_cross_y !== e.cy) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("mismatch: exp hit=%0b x=%0d y=%0d got hit=%0b x=%0d y=%0d",
                                 e.hit, e.cx, e.cy, o_hit, o_cross_x, o_cross_y);
                end
            end
        end
    end

endmodule
